// ===== rtl/core/qs_pkg.sv =====
`default_nettype none
package qs_pkg;

	localparam int unsigned FRAC_BITS = 30;
	localparam int unsigned CORDIC_STEPS = 30;
	localparam int unsigned SQRT_STEPS = 31;
	localparam int unsigned DIV_STEPS = 31;

	localparam logic [30:0] ONE_Q30 = 31'd1073741824;
	localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;
	localparam logic [30:0] CORDIC_KINV = 31'd652032874;
	localparam logic [30:0] NEAR_THRESHOLD_RESET = 31'd10737;

	localparam int unsigned ATAN_TAB_LEN = 11;
	localparam logic [30:0] ATAN_TAB [ATAN_TAB_LEN] = '{
		31'd843314857, 31'd497837829, 31'd263043837, 31'd133525159, 31'd67021687,
		31'd33543516, 31'd16775851, 31'd8388437, 31'd4194283, 31'd2097149,
		31'd1048576
	};

	// pipeline positions, counted in register levels from the input stage
	localparam int unsigned IX_ROOT = 2 + SQRT_STEPS;
	localparam int unsigned IX_THETA = IX_ROOT + CORDIC_STEPS;
	localparam int unsigned IX_PHI = IX_THETA + 1;
	localparam int unsigned IX_SINE = IX_PHI + CORDIC_STEPS;
	localparam int unsigned IX_QUOT = IX_SINE + 1 + DIV_STEPS;
	localparam int unsigned SB_DEPTH = IX_QUOT + 2;

	typedef logic signed [31:0] comp_t;
	typedef comp_t [3:0] quat_t;

	typedef struct packed {
		quat_t a;
		quat_t b;
		logic [30:0] alpha;
		logic flip;
		logic trig;
		logic [30:0] dm;
		logic [30:0] s;
	} sb_t;

	function automatic logic [30:0] atan_step(input int unsigned i);
		logic [30:0] r;
		if (i < ATAN_TAB_LEN) begin
			r = ATAN_TAB[i[3:0]];
		end else begin
			r = 31'(1) << (30 - i);
		end
		return r;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/core/qs_isqrt.sv =====
`default_nettype none
module qs_isqrt (
	input  logic        clk,
	input  logic        en,
	input  logic [60:0] rad,
	output logic [30:0] root
);
	import qs_pkg::*;

	logic [61:0] v_s [1:SQRT_STEPS];
	logic [61:0] r_s [1:SQRT_STEPS];
	logic [61:0] v_c [SQRT_STEPS];
	logic [61:0] r_c [SQRT_STEPS];

	for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_step
		localparam logic [61:0] BIT = 62'(1) << (60 - 2 * j);
		logic [61:0] t;
		if (j == 0) begin : g_first
			assign v_c[j] = {1'b0, rad};
			assign r_c[j] = '0;
		end else begin : g_rest
			assign v_c[j] = v_s[j];
			assign r_c[j] = r_s[j];
		end
		assign t = r_c[j] + BIT;
		always_ff @(posedge clk) begin
			if (en) begin
				if (v_c[j] >= t) begin
					v_s[j+1] <= v_c[j] - t;
					r_s[j+1] <= (r_c[j] >> 1) + BIT;
				end else begin
					v_s[j+1] <= v_c[j];
					r_s[j+1] <= r_c[j] >> 1;
				end
			end
		end
	end

	assign root = r_s[SQRT_STEPS][30:0];

endmodule
`default_nettype wire

// ===== rtl/core/qs_cordic_vec.sv =====
`default_nettype none
module qs_cordic_vec (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] x,
	input  logic [30:0] y,
	output logic [30:0] theta
);
	import qs_pkg::*;

	logic signed [33:0] x_s [1:CORDIC_STEPS];
	logic signed [33:0] y_s [1:CORDIC_STEPS];
	logic signed [32:0] z_s [1:CORDIC_STEPS];
	logic signed [33:0] x_c [CORDIC_STEPS];
	logic signed [33:0] y_c [CORDIC_STEPS];
	logic signed [32:0] z_c [CORDIC_STEPS];
	logic signed [32:0] z_end;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [32:0] ATN = $signed({2'b00, atan_step(i)});
		if (i == 0) begin : g_first
			assign x_c[i] = $signed({3'b000, x});
			assign y_c[i] = $signed({3'b000, y});
			assign z_c[i] = '0;
		end else begin : g_rest
			assign x_c[i] = x_s[i];
			assign y_c[i] = y_s[i];
			assign z_c[i] = z_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (y_c[i] > 0) begin
					x_s[i+1] <= x_c[i] + (y_c[i] >>> i);
					y_s[i+1] <= y_c[i] - (x_c[i] >>> i);
					z_s[i+1] <= z_c[i] + ATN;
				end else begin
					x_s[i+1] <= x_c[i] - (y_c[i] >>> i);
					y_s[i+1] <= y_c[i] + (x_c[i] >>> i);
					z_s[i+1] <= z_c[i] - ATN;
				end
			end
		end
	end

	assign z_end = z_s[CORDIC_STEPS];

	always_comb begin
		priority if (z_end < 0) begin
			theta = '0;
		end else if (z_end > $signed({2'b00, HALF_PI_Q30})) begin
			theta = HALF_PI_Q30;
		end else begin
			theta = z_end[30:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/qs_cordic_rot.sv =====
`default_nettype none
module qs_cordic_rot (
	input  logic        clk,
	input  logic        en,
	input  logic [30:0] phi,
	output logic [30:0] sine
);
	import qs_pkg::*;

	logic signed [33:0] x_s [1:CORDIC_STEPS];
	logic signed [33:0] y_s [1:CORDIC_STEPS];
	logic signed [32:0] z_s [1:CORDIC_STEPS];
	logic signed [33:0] x_c [CORDIC_STEPS];
	logic signed [33:0] y_c [CORDIC_STEPS];
	logic signed [32:0] z_c [CORDIC_STEPS];
	logic signed [33:0] y_end;

	for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
		localparam logic signed [32:0] ATN = $signed({2'b00, atan_step(i)});
		if (i == 0) begin : g_first
			assign x_c[i] = $signed({3'b000, CORDIC_KINV});
			assign y_c[i] = '0;
			assign z_c[i] = $signed({2'b00, phi});
		end else begin : g_rest
			assign x_c[i] = x_s[i];
			assign y_c[i] = y_s[i];
			assign z_c[i] = z_s[i];
		end
		always_ff @(posedge clk) begin
			if (en) begin
				if (z_c[i] >= 0) begin
					x_s[i+1] <= x_c[i] - (y_c[i] >>> i);
					y_s[i+1] <= y_c[i] + (x_c[i] >>> i);
					z_s[i+1] <= z_c[i] - ATN;
				end else begin
					x_s[i+1] <= x_c[i] + (y_c[i] >>> i);
					y_s[i+1] <= y_c[i] - (x_c[i] >>> i);
					z_s[i+1] <= z_c[i] + ATN;
				end
			end
		end
	end

	assign y_end = y_s[CORDIC_STEPS];

	always_comb begin
		priority if (y_end < 0) begin
			sine = '0;
		end else if (y_end > $signed({3'b000, ONE_Q30})) begin
			sine = ONE_Q30;
		end else begin
			sine = y_end[30:0];
		end
	end

endmodule
`default_nettype wire

// ===== rtl/core/qs_div.sv =====
`default_nettype none
module qs_div (
	input  logic        clk,
	input  logic        en,
	input  logic [60:0] num,
	input  logic [30:0] den,
	output logic [30:0] quot
);
	import qs_pkg::*;

	logic [61:0] rem_s [DIV_STEPS+1];
	logic [30:0] q_s [DIV_STEPS+1];
	logic [30:0] den_s [DIV_STEPS+1];
	logic        ovf_s [DIV_STEPS+1];

	// quotient at or above 2^31 saturates anyway
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= {1'b0, num};
			q_s[0]   <= '0;
			den_s[0] <= den;
			ovf_s[0] <= {1'b0, num} >= ({31'b0, den} << 31);
		end
	end

	for (genvar j = 0; j < DIV_STEPS; j++) begin : g_step
		localparam int unsigned B = DIV_STEPS - 1 - j;
		logic [61:0] sh;
		assign sh = {31'b0, den_s[j]} << B;
		always_ff @(posedge clk) begin
			if (en) begin
				den_s[j+1] <= den_s[j];
				ovf_s[j+1] <= ovf_s[j];
				if (rem_s[j] >= sh) begin
					rem_s[j+1] <= rem_s[j] - sh;
					q_s[j+1]   <= q_s[j] | (31'(1) << B);
				end else begin
					rem_s[j+1] <= rem_s[j];
					q_s[j+1]   <= q_s[j];
				end
			end
		end
	end

	assign quot = (ovf_s[DIV_STEPS] || q_s[DIV_STEPS] > ONE_Q30) ? ONE_Q30 : q_s[DIV_STEPS];

endmodule
`default_nettype wire

// ===== rtl/core/quaternion_slerp.sv =====
`default_nettype none
// Quaternion slerp, fully pipelined: one request per cycle except while in_stall is high.
// The pipeline holds the 31-step square root, the 30-step angle CORDIC, the 30-step
// sine CORDICs and the 31-step divider, each one register per step. A stall
// on the output freezes the whole pipeline; in_stall rises only while a result waits.
// near_threshold may be written at any time the pipeline holds no request; cfg_ready is
// always high. Components are signed Q2.30, blend is Q1.30 and saturates at 1.0.
module quaternion_slerp (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] a_real,
	input  logic signed [31:0] a_i,
	input  logic signed [31:0] a_j,
	input  logic signed [31:0] a_k,
	input  logic signed [31:0] b_real,
	input  logic signed [31:0] b_i,
	input  logic signed [31:0] b_j,
	input  logic signed [31:0] b_k,
	input  logic        [30:0] blend,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] out_real,
	output logic signed [31:0] out_i,
	output logic signed [31:0] out_j,
	output logic signed [31:0] out_k,
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic        [30:0] cfg_data
);
	import qs_pkg::*;

	logic        en;
	logic [30:0] thr_q;
	logic        vld_s [SB_DEPTH];
	sb_t         sb_s [IX_QUOT+1];
	sb_t         st2_c;
	sb_t         sb_root_c;
	quat_t       a_in, b_in;
	logic [30:0] alpha_in;

	logic signed [63:0] p_s1 [4];
	logic signed [35:0] dsum;
	logic        [35:0] ad;
	logic               trig_c;
	logic        [61:0] sq;
	logic        [60:0] rad_s3;
	logic        [30:0] root;
	logic        [30:0] theta;
	logic        [61:0] pr0, pr1;
	logic        [30:0] phi0_s, phi1_s;
	logic        [30:0] sine0, sine1;
	logic        [60:0] num0, num1;
	logic        [30:0] quot0, quot1;
	logic        [30:0] w0;
	logic        [30:0] w1m;
	logic signed [32:0] w1;
	logic signed [63:0] m0_s [4];
	logic signed [64:0] m1_s [4];
	logic signed [31:0] res_c [4];
	logic               out_valid_q;
	logic signed [31:0] out_q [4];

	assign en        = !(out_valid_q && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= NEAR_THRESHOLD_RESET;
		end else if (cfg_valid) begin
			thr_q <= cfg_data;
		end
	end

	assign a_in     = {a_k, a_j, a_i, a_real};
	assign b_in     = {b_k, b_j, b_i, b_real};
	assign alpha_in = (blend > ONE_Q30) ? ONE_Q30 : blend;

	// valid chain
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < SB_DEPTH; k++) vld_s[k] <= 1'b0;
			out_valid_q <= 1'b0;
		end else if (en) begin
			vld_s[0] <= in_valid;
			for (int k = 1; k < SB_DEPTH; k++) vld_s[k] <= vld_s[k-1];
			out_valid_q <= vld_s[SB_DEPTH-1];
		end
	end

	// stage 1: products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) p_s1[k] <= $signed(a_in[k]) * $signed(b_in[k]);
			sb_s[0].a     <= a_in;
			sb_s[0].b     <= b_in;
			sb_s[0].alpha <= alpha_in;
			sb_s[0].flip  <= 1'b0;
			sb_s[0].trig  <= 1'b0;
			sb_s[0].dm    <= '0;
			sb_s[0].s     <= '0;
		end
	end

	// stage 2: dot product, sign fold, near test
	always_comb begin
		dsum = '0;
		for (int k = 0; k < 4; k++) dsum = dsum + 36'(p_s1[k] >>> FRAC_BITS);
		ad = (dsum < 0) ? 36'(-dsum) : 36'(dsum);
		trig_c = (ad < {5'b0, ONE_Q30}) && ((ONE_Q30 - ad[30:0]) > thr_q);
		st2_c      = sb_s[0];
		st2_c.flip = dsum < 0;
		st2_c.trig = trig_c;
		st2_c.dm   = trig_c ? ad[30:0] : '0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[1] <= st2_c;
		end
	end

	// stage 3: radicand 1 - d^2
	assign sq = sb_s[1].dm * sb_s[1].dm;

	always_ff @(posedge clk) begin
		if (en) begin
			rad_s3 <= 61'((62'(1) << 60) - sq);
		end
	end

	always_comb begin
		sb_root_c   = sb_s[IX_ROOT];
		sb_root_c.s = root;
	end

	for (genvar k = 2; k <= IX_QUOT; k++) begin : g_sb
		always_ff @(posedge clk) begin
			if (en) begin
				sb_s[k] <= (k == IX_ROOT + 1) ? sb_root_c : sb_s[k-1];
			end
		end
	end

	qs_isqrt u_isqrt (
		.clk (clk),
		.en  (en),
		.rad (rad_s3),
		.root(root)
	);

	qs_cordic_vec u_vec (
		.clk  (clk),
		.en   (en),
		.x    (sb_s[IX_ROOT].dm),
		.y    (root),
		.theta(theta)
	);

	assign pr0 = theta * (ONE_Q30 - sb_s[IX_THETA].alpha);
	assign pr1 = theta * sb_s[IX_THETA].alpha;

	always_ff @(posedge clk) begin
		if (en) begin
			phi0_s <= pr0[60:30];
			phi1_s <= pr1[60:30];
		end
	end

	qs_cordic_rot u_rot0 (
		.clk (clk),
		.en  (en),
		.phi (phi0_s),
		.sine(sine0)
	);

	qs_cordic_rot u_rot1 (
		.clk (clk),
		.en  (en),
		.phi (phi1_s),
		.sine(sine1)
	);

	assign num0 = {sine0, 30'b0} + {31'b0, sb_s[IX_SINE].s[30:1]};
	assign num1 = {sine1, 30'b0} + {31'b0, sb_s[IX_SINE].s[30:1]};

	qs_div u_div0 (
		.clk (clk),
		.en  (en),
		.num (num0),
		.den (sb_s[IX_SINE].s),
		.quot(quot0)
	);

	qs_div u_div1 (
		.clk (clk),
		.en  (en),
		.num (num1),
		.den (sb_s[IX_SINE].s),
		.quot(quot1)
	);

	// weights and products
	assign w0  = sb_s[IX_QUOT].trig ? quot0 : (ONE_Q30 - sb_s[IX_QUOT].alpha);
	assign w1m = sb_s[IX_QUOT].trig ? quot1 : sb_s[IX_QUOT].alpha;
	assign w1  = sb_s[IX_QUOT].flip ? -$signed({2'b00, w1m}) : $signed({2'b00, w1m});

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) begin
				m0_s[k] <= $signed({1'b0, w0}) * $signed(sb_s[IX_QUOT].a[k]);
				m1_s[k] <= w1 * $signed(sb_s[IX_QUOT].b[k]);
			end
		end
	end

	// round and saturate
	always_comb begin
		logic signed [65:0] acc;
		logic signed [35:0] r;
		for (int k = 0; k < 4; k++) begin
			acc = 66'(m0_s[k]) + 66'(m1_s[k]) + (66'(1) <<< 29);
			r = 36'(acc >>> 30);
			priority if (r > 36'sd2147483647) begin
				res_c[k] = 32'sh7FFFFFFF;
			end else if (r < -36'sd2147483648) begin
				res_c[k] = 32'sh80000000;
			end else begin
				res_c[k] = r[31:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 4; k++) out_q[k] <= res_c[k];
		end
	end

	assign out_valid = out_valid_q;
	assign out_real  = out_q[0];
	assign out_i     = out_q[1];
	assign out_j     = out_q[2];
	assign out_k     = out_q[3];

endmodule
`default_nettype wire

// ===== tb/quaternion_slerp_check.sv =====
`default_nettype none
module quaternion_slerp_check (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	input  wire logic               in_stall,
	input  wire logic signed [31:0] a_real,
	input  wire logic signed [31:0] a_i,
	input  wire logic signed [31:0] a_j,
	input  wire logic signed [31:0] a_k,
	input  wire logic signed [31:0] b_real,
	input  wire logic signed [31:0] b_i,
	input  wire logic signed [31:0] b_j,
	input  wire logic signed [31:0] b_k,
	input  wire logic        [30:0] blend,
	input  wire logic               out_valid,
	input  wire logic               out_stall,
	input  wire logic signed [31:0] out_real,
	input  wire logic signed [31:0] out_i,
	input  wire logic signed [31:0] out_j,
	input  wire logic signed [31:0] out_k,
	input  wire logic               cfg_valid,
	input  wire logic               cfg_ready,
	input  wire logic        [30:0] cfg_data,
	output int                      failures,
	output int                      pending
);
	import qs_pkg::*;

	localparam longint UNIT = 64'sd1 << 30;
	localparam longint RIGHT_ANGLE = 64'sd1686629713;
	localparam longint GAIN_INV = 64'sd652032874;

	longint gap_limit;
	quat_t predicted_q[$];

	function automatic longint arc_step(int i);
		longint r;
		if (i < ATAN_TAB_LEN) begin
			r = longint'(ATAN_TAB[i]);
		end else begin
			r = 64'sd1 << (30 - i);
		end
		return r;
	endfunction

	function automatic longint root_floor(longint unsigned v);
		longint unsigned res, bitv;
		res = 0;
		bitv = 64'd1 << 62;
		while (bitv > v) bitv = bitv >> 2;
		while (bitv != 0) begin
			if (v >= res + bitv) begin
				v = v - (res + bitv);
				res = (res >> 1) + bitv;
			end else begin
				res = res >> 1;
			end
			bitv = bitv >> 2;
		end
		return longint'(res);
	endfunction

	function automatic longint vector_angle(longint x, longint y);
		longint z, xs, ys;
		z = 0;
		for (int i = 0; i < 30; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y > 0) begin
				x = x + ys; y = y - xs; z = z + arc_step(i);
			end else begin
				x = x - ys; y = y + xs; z = z - arc_step(i);
			end
		end
		if (z < 0) z = 0;
		if (z > RIGHT_ANGLE) z = RIGHT_ANGLE;
		return z;
	endfunction

	function automatic longint rotate_sine(longint z);
		longint x, y, xs, ys;
		x = GAIN_INV;
		y = 0;
		for (int i = 0; i < 30; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (z >= 0) begin
				x = x - ys; y = y + xs; z = z - arc_step(i);
			end else begin
				x = x + ys; y = y - xs; z = z + arc_step(i);
			end
		end
		if (y < 0) y = 0;
		if (y > UNIT) y = UNIT;
		return y;
	endfunction

	function automatic longint weight_of(longint sn, longint s);
		longint q;
		q = ((sn << 30) + (s >>> 1)) / s;
		if (q > UNIT) q = UNIT;
		return q;
	endfunction

	function automatic quat_t slerp_predict(quat_t qa, quat_t qb, logic [30:0] frac,
			longint thr);
		longint d, gap, alpha, w0, w1, s, theta, acc, r;
		logic flip;
		quat_t res;
		d = 0;
		for (int k = 0; k < 4; k++) d = d + ((longint'(qa[k]) * longint'(qb[k])) >>> 30);
		alpha = longint'(frac);
		if (alpha > UNIT) alpha = UNIT;
		flip = d < 0;
		if (flip) d = -d;
		gap = UNIT - d;
		w0 = UNIT - alpha;
		w1 = alpha;
		if (gap > thr) begin
			s = root_floor(longint'(UNIT * UNIT) - longint'(d * d));
			if (s > 0) begin
				theta = vector_angle(d, s);
				w0 = weight_of(rotate_sine((theta * (UNIT - alpha)) >>> 30), s);
				w1 = weight_of(rotate_sine((theta * alpha) >>> 30), s);
			end
		end
		if (flip) w1 = -w1;
		for (int k = 0; k < 4; k++) begin
			acc = w0 * longint'(qa[k]) + w1 * longint'(qb[k]) + (64'sd1 << 29);
			r = acc >>> 30;
			if (r > 64'sd2147483647) r = 64'sd2147483647;
			if (r < -64'sd2147483648) r = -64'sd2147483648;
			res[k] = r[31:0];
		end
		return res;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		quat_t qa, qb, got, want;
		if (!arst_n) begin
			gap_limit <= longint'(NEAR_THRESHOLD_RESET);
			predicted_q.delete();
			failures <= 0;
			pending <= 0;
		end else begin
			if (cfg_valid && cfg_ready) gap_limit <= longint'(cfg_data);
			if (in_valid && !in_stall) begin
				qa = '{a_k, a_j, a_i, a_real};
				qb = '{b_k, b_j, b_i, b_real};
				predicted_q.push_back(slerp_predict(qa, qb, blend, gap_limit));
			end
			if (out_valid && !out_stall) begin
				got = '{out_k, out_j, out_i, out_real};
				if (predicted_q.size() == 0) begin
					$error("result with no request outstanding");
					failures <= failures + 1;
				end else begin
					want = predicted_q.pop_front();
					if (got != want) failures <= failures + 1;
					if (got[0] != want[0])
						$error("out_real expected %0d got %0d", want[0], got[0]);
					if (got[1] != want[1])
						$error("out_i expected %0d got %0d", want[1], got[1]);
					if (got[2] != want[2])
						$error("out_j expected %0d got %0d", want[2], got[2]);
					if (got[3] != want[3])
						$error("out_k expected %0d got %0d", want[3], got[3]);
				end
			end
			pending <= predicted_q.size();
		end
	end
endmodule
`default_nettype wire

// ===== tb/quaternion_slerp_test.sv =====
`default_nettype none
module quaternion_slerp_test;
	import qs_pkg::*;

	localparam int DRAIN = 160;
	localparam int IDLE_LIMIT = 3000;

	logic clk = 0;
	logic arst_n = 0;
	logic in_valid = 0;
	logic in_stall;
	logic signed [31:0] a_real = 0, a_i = 0, a_j = 0, a_k = 0;
	logic signed [31:0] b_real = 0, b_i = 0, b_j = 0, b_k = 0;
	logic [30:0] blend = 0;
	logic out_valid;
	logic out_stall = 0;
	logic signed [31:0] out_real, out_i, out_j, out_k;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [30:0] cfg_data = 0;
	int failures, pending, idle_cycles = 0;
	logic quiet_in = 0;

	quaternion_slerp dut (.*);
	quaternion_slerp_check checker_i (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	function automatic int pause_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 70) return $urandom_range(0, 2);
		if (r < 95) return $urandom_range(3, 8);
		return $urandom_range(20, 60);
	endfunction

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles > IDLE_LIMIT) begin
			$display("quaternion_slerp regression: fail");
			$finish;
		end
	end

	initial begin
		int n;
		forever begin
			n = $urandom_range(0, 7) == 0 ? 200 : pause_len() + 1;
			out_stall <= 1'b0;
			repeat (n) @(posedge clk);
			n = $urandom_range(0, 5) == 0 ? 0 : pause_len();
			if (n > 0) begin
				out_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
		end
	end

	task automatic send_request(quat_t qa, quat_t qb, logic [30:0] frac);
		int g;
		{a_k, a_j, a_i, a_real} <= qa;
		{b_k, b_j, b_i, b_real} <= qb;
		blend <= frac;
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		g = quiet_in ? 0 : pause_len();
		if (g > 0) begin
			in_valid <= 1'b0;
			repeat (g) @(posedge clk);
		end
	endtask

	task automatic write_threshold(logic [30:0] v);
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		cfg_data <= v;
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	function automatic quat_t unit_ish();
		quat_t q;
		for (int k = 0; k < 4; k++) q[k] = $signed($urandom_range(0, 1 << 30)) - (1 << 29);
		return q;
	endfunction

	function automatic logic [30:0] rand_blend();
		case ($urandom_range(0, 9))
			0: return 31'd0;
			1: return ONE_Q30;
			2: return 31'($urandom);
			default: return 31'($urandom_range(0, 1 << 30));
		endcase
	endfunction

	task automatic random_requests(int count);
		quat_t qa, qb;
		for (int n = 0; n < count; n++) begin
			if (n % 50 == 0) quiet_in = $urandom_range(0, 3) == 0;
			qa = unit_ish();
			case ($urandom_range(0, 9))
				0, 1: for (int k = 0; k < 4; k++) begin
					qa[k] = $urandom;
					qb[k] = $urandom;
				end
				2: for (int k = 0; k < 4; k++)
					qb[k] = qa[k] + $signed($urandom_range(0, 4096)) - 2048;
				3: for (int k = 0; k < 4; k++)
					qb[k] = -qa[k] + $signed($urandom_range(0, 64)) - 32;
				default: qb = unit_ish();
			endcase
			send_request(qa, qb, rand_blend());
		end
		quiet_in = 0;
	endtask

	initial begin
		logic [30:0] levels [6];
		quat_t one_r, one_i, neg_r, zq, qmax, qmin;
		levels = '{31'd0, ONE_Q30, 31'h7FFFFFFF, 31'd10737, 31'd1 << 20, 31'd1 << 29};
		one_r = '{32'sd0, 32'sd0, 32'sd0, 32'sd1 << 30};
		one_i = '{32'sd0, 32'sd0, 32'sd1 << 30, 32'sd0};
		neg_r = '{32'sd0, 32'sd0, 32'sd0, -(32'sd1 << 30)};
		zq = '0;
		qmax = {4{32'sh7FFFFFFF}};
		qmin = {4{32'sh80000000}};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (DRAIN) @(posedge clk);
		// default threshold first
		send_request(zq, zq, 31'd0);
		send_request(qmax, qmax, 31'h7FFFFFFF);
		send_request(qmin, qmin, ONE_Q30);
		send_request(qmax, qmin, 31'd1 << 29);
		send_request(one_r, one_r, 31'd1 << 29);
		send_request(one_r, one_i, 31'd1 << 29);
		send_request(one_r, one_i, 31'd0);
		send_request(one_r, one_i, ONE_Q30);
		send_request(one_r, one_i, 31'h7FFFFFFF);
		send_request(one_r, neg_r, 31'd1 << 28);
		send_request(one_r, '{32'sd0, 32'sd0, 32'sd1 << 29, -(32'sd1 << 29)},
			31'd1 << 29);
		send_request({4{32'sd1 << 30}}, {4{32'sd1 << 30}}, 31'd12345);
		send_request(one_r, '{32'sd0, 32'sd0, 32'sd2000, 32'sd1073741000}, 31'd1 << 29);
		send_request(qmax, zq, 31'd1 << 30);
		foreach (levels[p]) begin
			write_threshold(levels[p]);
			random_requests(320);
		end
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (DRAIN) @(posedge clk);
		if (failures == 0)
			$display("quaternion_slerp regression: pass");
		else
			$display("quaternion_slerp regression: fail");
		$finish;
	end
endmodule
`default_nettype wire
